[rtl/rpsa_pkg.sv]
// Shared constants and types for the radix partition slot allocator.
`default_nettype none

package rpsa_pkg;

    localparam int MAX_RADIX_BITS = 10;
    localparam int SLOT_BITS      = 16;

    localparam int KEY_W   = 64;
    localparam int PAY_W   = 64;
    localparam int PART_W  = MAX_RADIX_BITS;
    localparam int SLOT_W  = SLOT_BITS;
    localparam int CNT_W   = SLOT_BITS + 1;
    localparam int RB_W    = 4;
    localparam int CAP_W   = 17;
    localparam int NUM_PARTS = 1 << MAX_RADIX_BITS;

    localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(1) << SLOT_BITS;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CAP_W;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX_BITS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = CFG_IDX_W'(1);

    localparam logic [RB_W-1:0]  RADIX_BITS_RESET = RB_W'(10);
    localparam logic [CAP_W-1:0] CAPACITY_RESET   = CAP_W'(65536);

    // Queue between front and back; depth is a power of two so pointers wrap
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
        logic              last;
        logic [PART_W-1:0] part;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] capacity;
    } t_cfg;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

`default_nettype wire

[rtl/rpsa_in_if.sv]
// Tuple input channel.
`default_nettype none

interface rpsa_in_if;
    logic                         valid;
    logic                         ready;
    logic [rpsa_pkg::KEY_W-1:0]   tuple_key;
    logic [rpsa_pkg::PAY_W-1:0]   tuple_payload;
    logic                         last_tuple;

    modport source (output valid, output tuple_key, output tuple_payload,
                    output last_tuple, input ready);
    modport sink   (input valid, input tuple_key, input tuple_payload,
                    input last_tuple, output ready);
endinterface

`default_nettype wire

[rtl/rpsa_out_if.sv]
// Slot result channel.
`default_nettype none

interface rpsa_out_if;
    logic                         valid;
    logic                         ready;
    logic [rpsa_pkg::PART_W-1:0]  part_index;
    logic [rpsa_pkg::SLOT_W-1:0]  slot_index;
    logic [rpsa_pkg::KEY_W-1:0]   out_key;
    logic [rpsa_pkg::PAY_W-1:0]   out_payload;
    logic                         overflow;
    logic                         last_out;

    modport source (output valid, output part_index, output slot_index, output out_key,
                    output out_payload, output overflow, output last_out, input ready);
    modport sink   (input valid, input part_index, input slot_index, input out_key,
                    input out_payload, input overflow, input last_out, output ready);
endinterface

`default_nettype wire

[rtl/rpsa_front.sv]
// Front end: configuration registers, input acceptance and partition selection.
`default_nettype none

module rpsa_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [rpsa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [rpsa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rpsa_in_if.sink                          i_tuple,
    input  wire rpsa_pkg::t_back_status      i_status,
    input  wire                              i_q_full,
    output logic                             o_push,
    output rpsa_pkg::t_item                  o_push_item,
    output rpsa_pkg::t_cfg                   o_cfg
);
    import rpsa_pkg::*;

    logic [RB_W-1:0]   r_radix_bits;
    logic [CAP_W-1:0]  r_capacity;
    logic [RB_W-1:0]   rb_eff;
    logic [PART_W-1:0] part_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix_bits <= RADIX_BITS_RESET;
            r_capacity   <= CAPACITY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RADIX_BITS: r_radix_bits <= i_cfg_data[RB_W-1:0];
                REG_CAPACITY:   r_capacity   <= i_cfg_data[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp radix width and build the low-bit mask
    always_comb begin
        rb_eff = (r_radix_bits > RB_W'(MAX_RADIX_BITS)) ? RB_W'(MAX_RADIX_BITS)
                                                         : r_radix_bits;
        for (int b = 0; b < PART_W; b++) begin
            part_mask[b] = (b < int'(rb_eff));
        end
    end

    assign o_cfg.capacity = (r_capacity > SLOT_LIMIT) ? SLOT_LIMIT : r_capacity;

    assign i_tuple.ready = !i_q_full && !i_status.clearing;
    assign o_push        = i_tuple.valid && i_tuple.ready;

    assign o_push_item.key     = i_tuple.tuple_key;
    assign o_push_item.payload = i_tuple.tuple_payload;
    assign o_push_item.last    = i_tuple.last_tuple;
    assign o_push_item.part    = i_tuple.tuple_key[PART_W-1:0] & part_mask;

endmodule

`default_nettype wire

[rtl/rpsa_queue.sv]
// Short item queue between front and back.
`default_nettype none

module rpsa_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire rpsa_pkg::t_item i_push_item,
    output logic                o_full,
    input  wire                 i_pop,
    output rpsa_pkg::t_item     o_head,
    output logic                o_empty
);
    import rpsa_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/rpsa_back.sv]
// Back end: fill counter memory, slot assignment and result register.
`default_nettype none

module rpsa_back (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire rpsa_pkg::t_cfg       i_cfg,
    input  wire                       i_q_empty,
    input  wire rpsa_pkg::t_item      i_q_head,
    output logic                      o_pop,
    output rpsa_pkg::t_back_status    o_status,
    rpsa_out_if.source                o_result
);
    import rpsa_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [PART_W-1:0]  r_clr_addr;
    t_item              r_item;
    logic [CNT_W-1:0]   r_fill [NUM_PARTS];
    logic [CNT_W-1:0]   r_rd_fill;
    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_out_slot;
    logic               r_out_ovf;
    t_item              r_out_item;

    logic               out_free;
    logic               ovf;
    logic               mem_we;
    logic [PART_W-1:0]  mem_waddr;
    logic [CNT_W-1:0]   mem_wdata;

    assign out_free = !r_out_valid || o_result.ready;
    assign o_pop    = (r_state == S_IDLE) && !i_q_empty && out_free;
    assign ovf      = (r_rd_fill >= i_cfg.capacity);

    assign o_status.clearing = (r_state == S_CLEAR);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == PART_W'(NUM_PARTS - 1)) n_state = S_IDLE;
            S_IDLE:  if (o_pop) n_state = S_LOOK;
            S_LOOK:  n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + PART_W'(1);
            end
        end
    end

    // counter memory: one write port, one registered read port
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = (r_state == S_LOOK) && !ovf;
            mem_waddr = r_item.part;
            mem_wdata = r_rd_fill + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_fill[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_fill <= r_fill[i_q_head.part];
            r_item    <= i_q_head;
        end
    end

    // result register; the pop condition keeps it free for the lookup cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_LOOK) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOOK) begin
            r_out_item <= r_item;
            r_out_ovf  <= ovf;
            r_out_slot <= ovf ? '0 : r_rd_fill[SLOT_W-1:0];
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.part_index  = r_out_item.part;
    assign o_result.slot_index  = r_out_slot;
    assign o_result.out_key     = r_out_item.key;
    assign o_result.out_payload = r_out_item.payload;
    assign o_result.overflow    = r_out_ovf;
    assign o_result.last_out    = r_out_item.last;

endmodule

`default_nettype wire

[rtl/radix_partition_slot_allocator.sv]
// Top level of the radix partition slot allocator.
//
//  channel     dir  handshake       payload
//  i_tuple     in   valid/ready     tuple_key, tuple_payload, last_tuple
//  o_result    out  valid/ready     part_index, slot_index, out_key, out_payload,
//                                   overflow, last_out
//  cfg         in   i_cfg_we        i_cfg_index, i_cfg_data (write only)
//
// In the back end S_IDLE reads an item's partition fill counter from the 1024-entry
// counter memory as the item is popped; S_LOOK then compares it, writes it back and
// loads the result register. No new item is popped while the back end is in S_LOOK.
// After reset the counter memory is cleared entry by entry; i_tuple.ready is low
// meanwhile. A two-entry queue lets input be taken while a result waits on o_result.
`default_nettype none

module radix_partition_slot_allocator (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [rpsa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [rpsa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rpsa_in_if.sink                          i_tuple,
    rpsa_out_if.source                       o_result
);
    import rpsa_pkg::*;

    t_back_status status;
    t_cfg         cfg;
    t_item        push_item;
    t_item        q_head;
    logic         push;
    logic         pop;
    logic         q_full;
    logic         q_empty;

    rpsa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tuple     (i_tuple),
        .i_status    (status),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_item (push_item),
        .o_cfg       (cfg)
    );

    rpsa_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_head      (q_head),
        .o_empty     (q_empty)
    );

    rpsa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .o_status  (status),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

[rtl/rpsa_checker.sv]
// Port-level checks for the radix partition slot allocator, with bind.
`default_nettype none

module rpsa_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_in_ready,
    input wire                              i_out_valid,
    input wire                              i_out_ready,
    input wire [rpsa_pkg::SLOT_W-1:0]       i_out_slot,
    input wire [rpsa_pkg::PART_W-1:0]       i_out_part,
    input wire                              i_out_ovf
);
    import rpsa_pkg::*;

    // reset empties the result register
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // counter clear pass blocks input after reset
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !i_in_ready)
        else $error("input ready during counter clear");

    // an overflowed tuple carries slot zero
    a_ovf_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ovf |-> i_out_slot == '0)
        else $error("overflow result with nonzero slot");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_slot) && $stable(i_out_part)
            && $stable(i_out_ovf))
        else $error("stalled result changed");

endmodule

bind radix_partition_slot_allocator rpsa_checker u_rpsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_tuple.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_slot  (o_result.slot_index),
    .i_out_part  (o_result.part_index),
    .i_out_ovf   (o_result.overflow)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the radix partition slot allocator.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rpsa_pkg::*;

    typedef struct packed {
        logic [PART_W-1:0] part;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
        logic              ovf;
        logic              last;
    } t_placement;

    // Write indexes past the register list; the block must ignore them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 60;
    localparam int MAX_IDLE       = 6;
    localparam int HOLD_OFF_CYCLES = 150;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    rpsa_in_if  tuple_ch ();
    rpsa_out_if result_ch ();

    radix_partition_slot_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tuple     (tuple_ch),
        .o_result    (result_ch)
    );

    // Shadow of the block's registers and fill counters
    logic [RB_W-1:0]  shadow_radix = RADIX_BITS_RESET;
    logic [CAP_W-1:0] shadow_capacity = CAPACITY_RESET;
    logic [CNT_W-1:0] fill_level [NUM_PARTS];

    t_placement pending_placements [$];
    t_placement got_placement;
    t_placement want_placement;
    logic [PART_W-1:0] hot_parts [4];

    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;
    int stall_left = 0;
    int hold_left = 0;
    int error_count = 0;
    int tuples_sent = 0;
    int results_checked = 0;
    int overflow_count = 0;
    int reg_writes = 0;

    always #10 i_clk = ~i_clk;

    initial begin
        tuple_ch.valid = 1'b0;
        tuple_ch.tuple_key = '0;
        tuple_ch.tuple_payload = '0;
        tuple_ch.last_tuple = 1'b0;
        result_ch.ready = 1'b0;
    end

    function automatic t_placement place_tuple(logic [KEY_W-1:0] key,
                                               logic [PAY_W-1:0] payload, logic last);
        logic [RB_W-1:0]   rb;
        logic [PART_W:0]   mask;
        logic [CNT_W-1:0]  cap;
        logic [CNT_W-1:0]  fill;
        t_placement        p;
        rb = (shadow_radix > RB_W'(MAX_RADIX_BITS)) ? RB_W'(MAX_RADIX_BITS) : shadow_radix;
        mask = ((PART_W+1)'(1) << rb) - (PART_W+1)'(1);
        cap = (shadow_capacity > SLOT_LIMIT) ? SLOT_LIMIT : shadow_capacity;
        p.part = key[PART_W-1:0] & mask[PART_W-1:0];
        p.key = key;
        p.payload = payload;
        p.last = last;
        fill = fill_level[p.part];
        if (fill >= cap) begin
            p.ovf = 1'b1;
            p.slot = '0;
        end else begin
            p.ovf = 1'b0;
            p.slot = fill[SLOT_W-1:0];
            fill_level[p.part] = fill + CNT_W'(1);
        end
        return p;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Half of the keys land on a few hot partitions so that they fill up
    function automatic logic [KEY_W-1:0] make_key();
        logic [KEY_W-1:0] key;
        key = rand64();
        if ($urandom_range(0, 1) == 0)
            key[PART_W-1:0] = hot_parts[$urandom_range(0, 3)];
        return key;
    endfunction

    task automatic send_tuple(logic [KEY_W-1:0] key, logic [PAY_W-1:0] payload, logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            tuple_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        tuple_ch.valid = 1'b1;
        tuple_ch.tuple_key = key;
        tuple_ch.tuple_payload = payload;
        tuple_ch.last_tuple = last;
        forever begin
            @(posedge i_clk);
            if (tuple_ch.ready) break;
        end
        pending_placements.push_back(place_tuple(key, payload, last));
        tuples_sent++;
    endtask

    // Hold the sender off until every expected result has come out
    task automatic drain_results();
        @(negedge i_clk);
        tuple_ch.valid = 1'b0;
        while (pending_placements.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain_results();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_RADIX_BITS)
            shadow_radix = data[RB_W-1:0];
        else if (idx == REG_CAPACITY)
            shadow_capacity = data;
        reg_writes++;
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            result_ch.ready = 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            result_ch.ready = 1'b0;
            stall_left--;
        end else begin
            result_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got_placement.part = result_ch.part_index;
            got_placement.slot = result_ch.slot_index;
            got_placement.key = result_ch.out_key;
            got_placement.payload = result_ch.out_payload;
            got_placement.ovf = result_ch.overflow;
            got_placement.last = result_ch.last_out;
            if (pending_placements.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time,
                         got_placement);
                error_count++;
            end else begin
                want_placement = pending_placements.pop_front();
                check_field("part_index", 64'(want_placement.part), 64'(got_placement.part));
                check_field("slot_index", 64'(want_placement.slot), 64'(got_placement.slot));
                check_field("out_key", want_placement.key, got_placement.key);
                check_field("out_payload", want_placement.payload, got_placement.payload);
                check_field("overflow", 64'(want_placement.ovf), 64'(got_placement.ovf));
                check_field("last_out", 64'(want_placement.last), 64'(got_placement.last));
                if (want_placement.ovf) overflow_count++;
            end
            results_checked++;
            stall_left = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        end
    end

    task automatic test_default_config();
        send_tuple(64'h0, 64'h0, 1'b0);
        send_tuple('1, '1, 1'b1);
        send_tuple(64'hFFFF_FFFF_FFFF_FC00, 64'h8000_0000_0000_0001, 1'b0);
        send_tuple(64'h0000_0000_0000_03FF, 64'h5555_5555_5555_5555, 1'b1);
        send_tuple(64'hAAAA_AAAA_AAAA_AAAA, 64'h0123_4567_89AB_CDEF, 1'b0);
    endtask

    task automatic test_register_corners();
        // zero radix bits: everything maps to partition zero
        set_reg(REG_RADIX_BITS, 17'h10000);
        send_tuple(rand64(), rand64(), 1'b0);
        send_tuple(rand64(), rand64(), 1'b1);
        // radix bits above the maximum clamp to ten
        set_reg(REG_RADIX_BITS, 17'h1FFFF);
        send_tuple(64'h1234_0000_0000_07FF, rand64(), 1'b0);
        set_reg(REG_RADIX_BITS, 17'h00001);
        send_tuple(64'h0000_0000_0000_0003, rand64(), 1'b0);
        // zero capacity: every tuple overflows
        set_reg(REG_CAPACITY, 17'h00000);
        send_tuple(64'h0, rand64(), 1'b1);
        send_tuple(64'h1, rand64(), 1'b0);
        set_reg(REG_RADIX_BITS, 17'h0000A);
        set_reg(REG_CAPACITY, 17'h00001);
        send_tuple(64'h0000_0000_0000_0123, rand64(), 1'b0);
        send_tuple(64'hFFFF_0000_0000_0123, rand64(), 1'b1);
        send_tuple(64'h0, rand64(), 1'b0);
        // writes past the register list change nothing
        set_reg(REG_SPARE_LO, 17'h00000);
        set_reg(REG_SPARE_HI, 17'h1FFFF);
        send_tuple(64'h0000_0000_0000_0123, rand64(), 1'b0);
        // capacity above the slot range clamps to the full range
        set_reg(REG_CAPACITY, 17'h1FFFF);
        send_tuple(64'h0000_0000_0000_0123, rand64(), 1'b1);
        set_reg(REG_CAPACITY, CAPACITY_RESET);
        send_tuple(64'h0000_0000_0000_0123, rand64(), 1'b0);
    endtask

    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] radix_word;
        logic [CFG_DATA_W-1:0] cap_word;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            radix_word = CFG_DATA_W'($urandom);
            case ($urandom_range(0, 4))
                0: radix_word[RB_W-1:0] = '0;
                1: radix_word[RB_W-1:0] = '1;
                2: radix_word[RB_W-1:0] = RB_W'(MAX_RADIX_BITS);
                default: ;
            endcase
            case ($urandom_range(0, 5))
                0: cap_word = '0;
                1: cap_word = CFG_DATA_W'($urandom_range(1, 8));
                2: cap_word = CFG_DATA_W'($urandom_range(1, 40));
                3: cap_word = CAPACITY_RESET;
                4: cap_word = '1;
                default: cap_word = CFG_DATA_W'($urandom);
            endcase
            set_reg(REG_RADIX_BITS, radix_word);
            set_reg(REG_CAPACITY, cap_word);
            if ($urandom_range(0, 3) == 0)
                set_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                        CFG_DATA_W'($urandom));
            foreach (hot_parts[i]) hot_parts[i] = PART_W'($urandom);
            tx_idle = (phase % 3 != 0);
            rx_idle = (phase != 0) && (phase % 3 != 2);
            repeat (PHASE_ITEMS) send_tuple(make_key(), rand64(), 1'($urandom));
        end
    endtask

    task automatic test_output_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        // drop the last offered item before waiting so it is not taken twice
        @(negedge i_clk);
        tuple_ch.valid = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
        repeat (30) send_tuple(make_key(), rand64(), 1'($urandom));
    endtask

    task automatic test_source_pause();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (12) send_tuple(make_key(), rand64(), 1'($urandom));
        drain_results();
        repeat (12) send_tuple(make_key(), rand64(), 1'($urandom));
    endtask

    initial begin
        for (int i = 0; i < NUM_PARTS; i++) fill_level[i] = '0;
        foreach (hot_parts[i]) hot_parts[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_config();
        test_register_corners();
        test_random_phases();
        test_output_backpressure();
        test_source_pause();

        drain_results();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d tuples over %0d register writes; %0d results checked, %0d overflowed.",
                 tuples_sent, reg_writes, results_checked, overflow_count);
        $display("Covered clamped and zero radix/capacity, ignored indexes, stalls and idles.");
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
